FILE: rtl/lcdtcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdtcw_pkg : shared types and constants for the LCD text cell writer
// Action codes, controller command bytes, run lengths and the 6x8 font.
// ----------------------------------------------------------------------------
package lcdtcw_pkg;

  // Panel geometry
  localparam int SCREEN_BYTES = 504;
  localparam int ROW_PIXELS   = 84;
  localparam int MAX_RUN      = 511;

  localparam logic [8:0] RUN_SCREEN =
    9'((SCREEN_BYTES > MAX_RUN) ? MAX_RUN : SCREEN_BYTES);
  localparam logic [8:0] RUN_ROW =
    9'((ROW_PIXELS > MAX_RUN) ? MAX_RUN : ROW_PIXELS);

  // Font coverage
  localparam logic [7:0] FIRST_GLYPH = 8'd32;
  localparam logic [7:0] LAST_GLYPH  = 8'd129;
  localparam int         GLYPHS      = 98;

  // Controller commands
  localparam logic [7:0] CMD_EXTENDED = 8'h21;
  localparam logic [7:0] CMD_VOP      = 8'h80;
  localparam logic [7:0] CMD_TEMP     = 8'h04;
  localparam logic [7:0] CMD_BIAS     = 8'h10;
  localparam logic [7:0] CMD_BASIC    = 8'h20;
  localparam logic [7:0] CMD_NORMAL   = 8'h0c;
  localparam logic [7:0] CMD_SET_Y    = 8'h40;
  localparam logic [7:0] CMD_SET_X    = 8'h80;

  // Number of set-up commands ahead of the screen clear in init
  localparam logic [3:0] INIT_CMDS = 4'd6;

  typedef enum logic [1:0] {
    ACT_INIT       = 2'd0,
    ACT_CLEAR      = 2'd1,
    ACT_WRITE_CHAR = 2'd2,
    ACT_CLEAR_LINE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_CONTRAST = 2'd0,
    CFG_TEMP     = 2'd1,
    CFG_BIAS     = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [6:0] contrast_voltage;
    logic [1:0] temperature_coefficient;
    logic [2:0] bias_setting;
  } cfg_t;

  typedef struct packed {
    action_e    action;
    logic [2:0] text_row;
    logic [3:0] text_column;
    logic [6:0] glyph_index;
  } item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
    logic [8:0] repeat_count;
    logic       last;
  } result_t;

  // Font: one 48-bit word per glyph, leftmost column in the top byte
  localparam logic [47:0] GLYPH_ROM [0:GLYPHS-1] = '{
    48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
    48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
    48'h00001c224100, 48'h000041221c00, 48'h0014083e0814, 48'h0008083e0808,
    48'h000000a06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003e5149453e, 48'h0000427f4000, 48'h004261514946, 48'h002141454b31,
    48'h001814127f10, 48'h002745454539, 48'h003c4a494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291e, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324959513e, 48'h007c1211127c, 48'h007f49494936, 48'h003e41414122,
    48'h007f4141221c, 48'h007f49494941, 48'h007f09090901, 48'h003e4149497a,
    48'h007f0808087f, 48'h0000417f4100, 48'h002040413f01, 48'h007f08142241,
    48'h007f40404040, 48'h007f020c027f, 48'h007f0408107f, 48'h003e4141413e,
    48'h007f09090906, 48'h003e4151215e, 48'h007f09192946, 48'h004649494931,
    48'h0001017f0101, 48'h003f4040403f, 48'h001f2040201f, 48'h003f4038403f,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007f414100,
    48'h00552a552a55, 48'h000041417f00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007f48444438, 48'h003844444420,
    48'h00384444487f, 48'h003854545418, 48'h00087e090102, 48'h0018a4a4a47c,
    48'h007f08040478, 48'h0000447d4000, 48'h004080847d00, 48'h007f10284400,
    48'h0000417f4000, 48'h007c04180478, 48'h007c08040478, 48'h003844444438,
    48'h00fc24242418, 48'h0018242418fc, 48'h007c08040408, 48'h004854545420,
    48'h00043f444020, 48'h003c4040207c, 48'h001c2040201c, 48'h003c4030403c,
    48'h004428102844, 48'h001ca0a0a07c, 48'h004464544c44, 48'h0000ffff0000,
    48'h081c2a080808, 48'h0808082a1c08, 48'h0402ff020400, 48'h002040ff4020,
    48'h000101ff8181, 48'h008080ff8080
  };

endpackage

`default_nettype wire

FILE: rtl/lcdtcw_result_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdtcw_result_gen : result selection for one step of an item
// Maps the held item and its step number to one command or data result.
// ----------------------------------------------------------------------------
module lcdtcw_result_gen (
  input  lcdtcw_pkg::item_t   item_i,
  input  logic [3:0]          step_i,
  input  lcdtcw_pkg::cfg_t    cfg_i,
  output lcdtcw_pkg::result_t result_o
);
  import lcdtcw_pkg::*;

  logic [6:0]  x_addr;
  logic [3:0]  clr_step;
  logic [47:0] glyph_word;
  logic [7:0]  glyph_col;
  result_t     clr_res;

  // column * 6 as shift-and-add
  assign x_addr = ({3'b000, item_i.text_column} << 2) + ({3'b000, item_i.text_column} << 1);

  assign glyph_word = GLYPH_ROM[item_i.glyph_index];

  always_comb begin
    case (step_i)
      4'd2:    glyph_col = glyph_word[47:40];
      4'd3:    glyph_col = glyph_word[39:32];
      4'd4:    glyph_col = glyph_word[31:24];
      4'd5:    glyph_col = glyph_word[23:16];
      4'd6:    glyph_col = glyph_word[15:8];
      default: glyph_col = glyph_word[7:0];
    endcase
  end

  // screen clear tail, shared by init and clear
  assign clr_step = (item_i.action == ACT_INIT) ? (step_i - INIT_CMDS) : step_i;

  always_comb begin
    case (clr_step)
      4'd0:    clr_res = '{is_data: 1'b0, byte_value: CMD_NORMAL, repeat_count: 9'd1,
                           last: 1'b0};
      4'd1:    clr_res = '{is_data: 1'b0, byte_value: CMD_SET_X, repeat_count: 9'd1,
                           last: 1'b0};
      default: clr_res = '{is_data: 1'b1, byte_value: 8'h00, repeat_count: RUN_SCREEN,
                           last: 1'b1};
    endcase
  end

  always_comb begin
    result_o = '{is_data: 1'b0, byte_value: 8'h00, repeat_count: 9'd1, last: 1'b0};
    case (item_i.action)
      ACT_INIT: begin
        case (step_i)
          4'd0: result_o.byte_value = CMD_EXTENDED;
          4'd1: result_o.byte_value = CMD_VOP | {1'b0, cfg_i.contrast_voltage};
          4'd2: result_o.byte_value = CMD_TEMP | {6'd0, cfg_i.temperature_coefficient};
          4'd3: result_o.byte_value = CMD_BIAS | {5'd0, cfg_i.bias_setting};
          4'd4: result_o.byte_value = CMD_BASIC;
          4'd5: result_o.byte_value = CMD_NORMAL;
          default: result_o = clr_res;
        endcase
      end
      ACT_CLEAR: begin
        result_o = clr_res;
      end
      ACT_WRITE_CHAR: begin
        case (step_i)
          4'd0: result_o.byte_value = CMD_SET_Y | {5'd0, item_i.text_row};
          4'd1: result_o.byte_value = CMD_SET_X | {1'b0, x_addr};
          default: begin
            result_o.is_data    = 1'b1;
            result_o.byte_value = glyph_col;
            result_o.last       = (step_i >= 4'd7);
          end
        endcase
      end
      default: begin
        case (step_i)
          4'd0: result_o.byte_value = CMD_SET_Y | {5'd0, item_i.text_row};
          4'd1: result_o.byte_value = CMD_SET_X;
          default: result_o = '{is_data: 1'b1, byte_value: 8'h00, repeat_count: RUN_ROW,
                                 last: 1'b1};
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lcd_text_cell_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_text_cell_writer : command/data byte generator for an 84x48 text LCD
// Turns init, clear, write-character and clear-line requests into runs of
// controller bytes for a serial shifter downstream.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o): one request per transfer.
//   Output channel (out_valid_o / out_stall_i): one result per transfer,
//   a byte with its D/C flag, a repeat count for zero runs, and a last flag
//   on the final result of each request.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; write only
//   while the block is idle.
// Timing
//   The first result of a request is formed from the registered request,
//   then held in the output register. One result leaves per cycle while
//   out_stall_i is low. Results per request: init 9, clear 3, write char 8,
//   clear line 3. The next request is taken in the cycle its predecessor's
//   last result is produced, so requests run back to back.
// Reset
//   Clears the request and output valid flags and loads the default
//   contrast (72), temperature coefficient (2) and bias (3).
// Stall
//   A stalled result is held in the output register; the request stage
//   then holds too and in_stall_o rises until the output can move.
// ----------------------------------------------------------------------------
module lcd_text_cell_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [2:0] text_row_i,
  input  logic [3:0] text_column_i,
  input  logic [7:0] glyph_code_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] byte_value_o,
  output logic [8:0] repeat_count_o,
  output logic       last_o,
  // configuration channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  import lcdtcw_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q, item_d;
  logic    item_valid_q;
  logic [3:0] step_q;
  result_t res, out_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  // --- configuration registers -------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{contrast_voltage: 7'd72, temperature_coefficient: 2'd2,
                 bias_setting: 3'd3};
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_CONTRAST: cfg_q.contrast_voltage        <= cfg_data_i;
        CFG_TEMP:     cfg_q.temperature_coefficient <= cfg_data_i[1:0];
        CFG_BIAS:     cfg_q.bias_setting            <= cfg_data_i[2:0];
        default:      ;  // unmapped index: write dropped
      endcase
    end
  end

  // --- request stage ------------------------------------------------------
  // A result moves into the output register when one is pending and the
  // output register is empty or draining this cycle.
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !(advance && res.last);
  assign in_take    = in_valid_i && !in_stall_o;

  // glyph remap: codes outside the font draw a space
  always_comb begin
    item_d.action      = action_e'(action_i);
    item_d.text_row    = text_row_i;
    item_d.text_column = text_column_i;
    if (glyph_code_i < FIRST_GLYPH || glyph_code_i > LAST_GLYPH) begin
      item_d.glyph_index = 7'd0;
    end else begin
      item_d.glyph_index = 7'(glyph_code_i - FIRST_GLYPH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= 4'd0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
      step_q       <= 4'd0;
    end else if (advance) begin
      if (res.last) begin
        item_valid_q <= 1'b0;
      end
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  lcdtcw_result_gen u_result_gen (
    .item_i   (item_q),
    .step_i   (step_q),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  // --- output register ----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_data_o      = out_q.is_data;
  assign byte_value_o   = out_q.byte_value;
  assign repeat_count_o = out_q.repeat_count;
  assign last_o         = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/lcdtcw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdtcw_checker : port-level checks for the LCD text cell writer
// Result shape rules and output hold under stall, bound to the top level.
// ----------------------------------------------------------------------------
module lcdtcw_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic       is_data_o,
  input  logic [7:0] byte_value_o,
  input  logic [8:0] repeat_count_o,
  input  logic       last_o
);

  // stalled result stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // stalled result keeps its byte
  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_value_o) && $stable(last_o))
    else $error("result changed under stall");

  // commands are never folded into runs
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> repeat_count_o == 9'd1)
    else $error("command with repeat count");

  // runs are zero data and always end a request
  a_run_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && repeat_count_o != 9'd1 |->
      is_data_o && byte_value_o == 8'h00 && last_o && repeat_count_o != 9'd0)
    else $error("malformed zero run");

endmodule

bind lcd_text_cell_writer lcdtcw_checker u_lcdtcw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_data_o      (is_data_o),
  .byte_value_o   (byte_value_o),
  .repeat_count_o (repeat_count_o),
  .last_o         (last_o)
);

`default_nettype wire
